>>> design/xsp_pkg.sv
`default_nettype none

package xsp_pkg;

  localparam int unsigned PC_W = 4;
  localparam int unsigned OP_W = 4;
  localparam int unsigned JMP_W = 2;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;

  localparam int unsigned WARMUP_DRAWS = 3;

  localparam logic [OP_W-1:0] OP_NOP = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
  localparam logic [OP_W-1:0] OP_GAMMA = 4'd2;
  localparam logic [OP_W-1:0] OP_XS30 = 4'd3;
  localparam logic [OP_W-1:0] OP_XS27 = 4'd4;
  localparam logic [OP_W-1:0] OP_XS31 = 4'd5;
  localparam logic [OP_W-1:0] OP_MUL0 = 4'd6;
  localparam logic [OP_W-1:0] OP_MUL1 = 4'd7;
  localparam logic [OP_W-1:0] OP_MUL2 = 4'd8;
  localparam logic [OP_W-1:0] OP_MUL3 = 4'd9;
  localparam logic [OP_W-1:0] OP_STORE = 4'd10;
  localparam logic [OP_W-1:0] OP_ADV = 4'd11;

  localparam logic [JMP_W-1:0] JMP_NEXT = 2'd0;
  localparam logic [JMP_W-1:0] JMP_ROUND = 2'd1;
  localparam logic [JMP_W-1:0] JMP_WARM = 2'd2;

  localparam logic CSEL_A = 1'b0;
  localparam logic CSEL_B = 1'b1;

  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_ROUND = 4'd1;
  localparam logic [PC_W-1:0] PC_WARM = 4'd14;

  typedef logic [3:0][63:0] words_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic csel;
  } mix_ctrl_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic csel;
    logic [JMP_W-1:0] jmp;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, csel: CSEL_A, jmp: JMP_NEXT, target: PC_IDLE};
    unique case (pc)
      4'd1: w.op = OP_GAMMA;
      4'd2: w.op = OP_XS30;
      4'd3: w = '{op: OP_MUL0, csel: CSEL_A, jmp: JMP_NEXT, target: PC_IDLE};
      4'd4: w = '{op: OP_MUL1, csel: CSEL_A, jmp: JMP_NEXT, target: PC_IDLE};
      4'd5: w = '{op: OP_MUL2, csel: CSEL_A, jmp: JMP_NEXT, target: PC_IDLE};
      4'd6: w.op = OP_MUL3;
      4'd7: w.op = OP_XS27;
      4'd8: w = '{op: OP_MUL0, csel: CSEL_B, jmp: JMP_NEXT, target: PC_IDLE};
      4'd9: w = '{op: OP_MUL1, csel: CSEL_B, jmp: JMP_NEXT, target: PC_IDLE};
      4'd10: w = '{op: OP_MUL2, csel: CSEL_B, jmp: JMP_NEXT, target: PC_IDLE};
      4'd11: w.op = OP_MUL3;
      4'd12: w.op = OP_XS31;
      4'd13: w = '{op: OP_STORE, csel: CSEL_A, jmp: JMP_ROUND, target: PC_ROUND};
      4'd14: w = '{op: OP_ADV, csel: CSEL_A, jmp: JMP_WARM, target: PC_WARM};
      default: w = '{op: OP_NOP, csel: CSEL_A, jmp: JMP_NEXT, target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> design/xsp_mix_unit.sv
`default_nettype none

module xsp_mix_unit (
  input  wire logic              clk,
  input  wire xsp_pkg::mix_ctrl_t ctrl,
  input  wire logic [63:0]       seed,
  output logic [63:0]            mix_z
);

  logic [63:0] cnt_r, cnt_nxt;
  logic [63:0] z_r, z_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] mul_c;
  logic [31:0] mul_a, mul_b;
  logic [63:0] cnt_sum;
  logic [63:0] acc_sum;

  assign mul_c = (ctrl.csel == xsp_pkg::CSEL_B) ? xsp_pkg::MIX_MUL_B : xsp_pkg::MIX_MUL_A;
  assign cnt_sum = cnt_r + xsp_pkg::GOLDEN_GAMMA;
  assign acc_sum = acc_r + {prod_r[31:0], 32'd0};

  always_comb begin
    unique case (ctrl.op)
      xsp_pkg::OP_MUL1: begin
        mul_a = z_r[31:0];
        mul_b = mul_c[63:32];
      end
      xsp_pkg::OP_MUL2: begin
        mul_a = z_r[63:32];
        mul_b = mul_c[31:0];
      end
      default: begin
        mul_a = z_r[31:0];
        mul_b = mul_c[31:0];
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    z_nxt = z_r;
    acc_nxt = acc_r;
    prod_nxt = mul_a * mul_b;
    case (ctrl.op)
      xsp_pkg::OP_LOAD: cnt_nxt = seed;
      xsp_pkg::OP_GAMMA: begin
        cnt_nxt = cnt_sum;
        z_nxt = cnt_sum;
      end
      xsp_pkg::OP_XS30: z_nxt = z_r ^ (z_r >> 30);
      xsp_pkg::OP_XS27: z_nxt = z_r ^ (z_r >> 27);
      xsp_pkg::OP_XS31: z_nxt = z_r ^ (z_r >> 31);
      xsp_pkg::OP_MUL1: acc_nxt = prod_r;
      xsp_pkg::OP_MUL2: acc_nxt = acc_sum;
      xsp_pkg::OP_MUL3: z_nxt = acc_sum;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    z_r <= z_nxt;
    acc_r <= acc_nxt;
    prod_r <= prod_nxt;
  end

  assign mix_z = z_r;

endmodule

`default_nettype wire

>>> design/xoshiro256plus_prng_splitmix_seed.sv
`default_nettype none

// Channel  Direction  tdata                          tuser
// in       slave      stream_index[31:0]             kind[0]
// out      master     raw_value[63:0],               -
//                     uniform_fraction[116:64], pad
// cfg      write      cfg_wdata = base_seed[63:0]    -
//
// A draw beat is taken while in_tready is high and its result sits in the output
// register the cycle after, so draws run at one per cycle while the output is taken.
// A seed beat runs a 14-step microprogram on one shared 32x32 multiplier: two passes over
// its 13 mixing steps plus 3 warm-up steps, with in_tready low throughout.
// Reset clears the generator state, the base seed and the output valid flag; a stalled
// result holds and blocks further beats only while it stays untaken.

module xoshiro256plus_prng_splitmix_seed (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [63:0]   cfg_wdata,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [31:0]   in_tdata,   // stream_index[31:0]
  input  wire logic [0:0]    in_tuser,   // kind[0]
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [119:0]       out_tdata   // raw_value[63:0], uniform_fraction[116:64]
);

  logic [63:0] base_seed_r;
  logic [xsp_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic round_r, round_nxt;
  logic [1:0] warm_r, warm_nxt;
  xsp_pkg::words_t words_r, words_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [63:0] raw_r, raw_nxt;
  xsp_pkg::uword_t uw;
  xsp_pkg::mix_ctrl_t mix_ctrl;
  logic [63:0] mix_z;
  logic [63:0] seed;
  logic in_hs;

  function automatic xsp_pkg::words_t advance(input xsp_pkg::words_t w);
    xsp_pkg::words_t s;
    logic [63:0] t;
    s = w;
    t = s[1] << 17;
    s[2] = s[2] ^ s[0];
    s[3] = s[3] ^ s[1];
    s[1] = s[1] ^ s[2];
    s[0] = s[0] ^ s[3];
    s[2] = s[2] ^ t;
    s[3] = {s[3][18:0], s[3][63:19]};
    return s;
  endfunction

  assign uw = xsp_pkg::ucode(pc_r);
  assign in_tready = (pc_r == xsp_pkg::PC_IDLE) && (!out_valid_r || out_tready);
  assign in_hs = in_tvalid && in_tready;
  assign seed = base_seed_r + {32'd0, in_tdata};

  always_comb begin
    mix_ctrl.op = uw.op;
    mix_ctrl.csel = uw.csel;
    if (in_hs && !in_tuser[0]) begin
      mix_ctrl.op = xsp_pkg::OP_LOAD;
    end
  end

  xsp_mix_unit u_mix (
    .clk   (clk),
    .ctrl  (mix_ctrl),
    .seed  (seed),
    .mix_z (mix_z)
  );

  always_comb begin
    pc_nxt = pc_r;
    round_nxt = round_r;
    warm_nxt = warm_r;
    words_nxt = words_r;
    raw_nxt = raw_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (pc_r == xsp_pkg::PC_IDLE) begin
      if (in_hs) begin
        if (in_tuser[0]) begin
          raw_nxt = words_r[0] + words_r[3];
          words_nxt = advance(words_r);
          out_valid_nxt = 1'b1;
        end else begin
          pc_nxt = xsp_pkg::PC_ROUND;
          round_nxt = 1'b0;
          warm_nxt = 2'd0;
        end
      end
    end else begin
      case (uw.op)
        xsp_pkg::OP_STORE: begin
          if (round_r) begin
            words_nxt[2] = {32'd0, mix_z[31:0]};
            words_nxt[3] = {32'd0, mix_z[63:32]};
          end else begin
            words_nxt[0] = {32'd0, mix_z[31:0]};
            words_nxt[1] = {32'd0, mix_z[63:32]};
          end
        end
        xsp_pkg::OP_ADV: words_nxt = advance(words_r);
        default: ;
      endcase
      unique case (uw.jmp)
        xsp_pkg::JMP_ROUND: begin
          if (!round_r) begin
            round_nxt = 1'b1;
            pc_nxt = uw.target;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
        xsp_pkg::JMP_WARM: begin
          if (warm_r == 2'(xsp_pkg::WARMUP_DRAWS - 1)) begin
            pc_nxt = xsp_pkg::PC_IDLE;
          end else begin
            warm_nxt = warm_r + 1'b1;
            pc_nxt = uw.target;
          end
        end
        default: pc_nxt = pc_r + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_seed_r <= '0;
      pc_r <= xsp_pkg::PC_IDLE;
      round_r <= 1'b0;
      warm_r <= 2'd0;
      words_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_seed_r <= cfg_wdata;
      end
      pc_r <= pc_nxt;
      round_r <= round_nxt;
      warm_r <= warm_nxt;
      words_r <= words_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r <= raw_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {3'd0, raw_r[63:11], raw_r};

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> pc_r == xsp_pkg::PC_IDLE)
    else $error("input taken while the microprogram is running");

  a_draw_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_hs && in_tuser[0] |=> out_tvalid)
    else $error("draw beat gave no result");

  a_seed_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_hs && !in_tuser[0] |=> !out_tvalid && pc_r == xsp_pkg::PC_ROUND)
    else $error("seed beat gave a result or did not start seeding");

  a_warm_exit: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == xsp_pkg::PC_WARM && warm_r == 2'(xsp_pkg::WARMUP_DRAWS - 1)
      |=> pc_r == xsp_pkg::PC_IDLE)
    else $error("warm-up loop did not end after its last draw");

endmodule

`default_nettype wire

>>> dv/xsp_tb_pkg.sv
package xsp_tb_pkg;

  typedef enum logic {
    KIND_SEED = 1'b0,
    KIND_DRAW = 1'b1
  } beat_kind_e;

endpackage

>>> dv/xsp_stream_checker.sv
module xsp_stream_checker (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [63:0]   cfg_wdata,
  input  wire logic          in_tvalid,
  input  wire logic          in_tready,
  input  wire logic [31:0]   in_tdata,   // stream_index[31:0]
  input  wire logic [0:0]    in_tuser,   // kind[0]
  input  wire logic          out_tvalid,
  input  wire logic          out_tready,
  input  wire logic [119:0]  out_tdata,  // raw_value[63:0], uniform_fraction[116:64]
  output int                 fail_count,
  output int                 results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] raw_value;
    logic [52:0] uniform_fraction;
  } draw_result_t;

  draw_result_t    owed_q[$];
  xsp_pkg::words_t gen_words = '0;
  logic [63:0]     seed_base = '0;
  int              err_cnt = 0;

  function automatic logic [63:0] splitmix_mix(input logic [63:0] z0);
    logic [63:0] z;
    z = (z0 ^ (z0 >> 30)) * xsp_pkg::MIX_MUL_A;
    z = (z ^ (z >> 27)) * xsp_pkg::MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  function automatic xsp_pkg::words_t xoshiro_step(input xsp_pkg::words_t w);
    xsp_pkg::words_t n;
    logic [63:0]     t;
    n = w;
    t = w[1] << 17;
    n[2] = n[2] ^ n[0];
    n[3] = n[3] ^ n[1];
    n[1] = n[1] ^ n[2];
    n[0] = n[0] ^ n[3];
    n[2] = n[2] ^ t;
    n[3] = {n[3][18:0], n[3][63:19]};
    return n;
  endfunction

  function automatic xsp_pkg::words_t seeded_words(input logic [63:0] base,
                                                   input logic [31:0] idx);
    xsp_pkg::words_t w;
    logic [63:0]     ctr;
    logic [63:0]     r;
    ctr = base + {32'd0, idx} + xsp_pkg::GOLDEN_GAMMA;
    r = splitmix_mix(ctr);
    w[0] = {32'd0, r[31:0]};
    w[1] = {32'd0, r[63:32]};
    ctr = ctr + xsp_pkg::GOLDEN_GAMMA;
    r = splitmix_mix(ctr);
    w[2] = {32'd0, r[31:0]};
    w[3] = {32'd0, r[63:32]};
    for (int i = 0; i < xsp_pkg::WARMUP_DRAWS; i++) w = xoshiro_step(w);
    return w;
  endfunction

  always @(posedge clk) begin : watch
    draw_result_t want;
    draw_result_t got;
    if (!rst_n) begin
      gen_words = '0;
      seed_base = '0;
      owed_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        if (xsp_tb_pkg::beat_kind_e'(in_tuser[0]) == xsp_tb_pkg::KIND_SEED) begin
          gen_words = seeded_words(seed_base, in_tdata);
        end else begin
          want.raw_value = gen_words[0] + gen_words[3];
          want.uniform_fraction = want.raw_value[63:11];
          owed_q.push_back(want);
          gen_words = xoshiro_step(gen_words);
        end
      end
      if (cfg_we) seed_base = cfg_wdata;
      if (out_tvalid && out_tready) begin
        got.raw_value = out_tdata[63:0];
        got.uniform_fraction = out_tdata[116:64];
        if (owed_q.size() == 0) begin
          err_cnt++;
          $error("Result beat with no draw outstanding: raw_value %h", got.raw_value);
        end else begin
          want = owed_q.pop_front();
          if (got.raw_value !== want.raw_value) begin
            err_cnt++;
            $error("raw_value mismatch: expected %h, actual %h",
                   want.raw_value, got.raw_value);
          end
          if (got.uniform_fraction !== want.uniform_fraction) begin
            err_cnt++;
            $error("uniform_fraction mismatch: expected %h, actual %h",
                   want.uniform_fraction, got.uniform_fraction);
          end
        end
      end
    end
    fail_count <= err_cnt;
    results_owed <= owed_q.size();
  end

endmodule

>>> dv/tb_xoshiro256plus_prng_splitmix_seed.sv
module tb_xoshiro256plus_prng_splitmix_seed;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SEED_LATENCY = 40;
  localparam int unsigned HOLD_CYCLES = 300;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [63:0]   cfg_wdata;
  logic          in_tvalid;
  logic          in_tready;
  logic [31:0]   in_tdata;
  logic [0:0]    in_tuser;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [119:0]  out_tdata;
  int            fail_count;
  int            results_owed;

  logic          calm = 1'b0;
  logic          hold_go = 1'b0;
  logic          hold_used = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   cycle_cnt = 0;

  xoshiro256plus_prng_splitmix_seed dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  xsp_stream_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // The long hold-off is counted here so that the sender keeps offering beats meanwhile.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 35);
    end
  end

  task automatic offer_beat(input xsp_tb_pkg::beat_kind_e kind, input logic [31:0] idx);
    while (!calm && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= idx;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SEED_LATENCY) @(posedge clk);
  endtask

  task automatic write_base_seed(input logic [63:0] seed);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_index();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) offer_beat(xsp_tb_pkg::KIND_SEED, pick_index());
      else offer_beat(xsp_tb_pkg::KIND_DRAW, $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Draws before any seed must return zero, since the cleared state is a fixed point.
    offer_beat(xsp_tb_pkg::KIND_DRAW, 32'hFFFF_FFFF);
    offer_beat(xsp_tb_pkg::KIND_DRAW, 32'd0);
    offer_beat(xsp_tb_pkg::KIND_DRAW, 32'h5A5A_A5A5);
    offer_beat(xsp_tb_pkg::KIND_SEED, 32'd0);
    repeat (3) offer_beat(xsp_tb_pkg::KIND_DRAW, 32'd0);
    offer_beat(xsp_tb_pkg::KIND_SEED, 32'hFFFF_FFFF);
    repeat (2) offer_beat(xsp_tb_pkg::KIND_DRAW, 32'hFFFF_FFFF);
    offer_beat(xsp_tb_pkg::KIND_SEED, 32'h8000_0000);
    repeat (2) offer_beat(xsp_tb_pkg::KIND_DRAW, 32'd0);

    // With an all-ones base the seed sum wraps.
    write_base_seed(64'hFFFF_FFFF_FFFF_FFFF);
    offer_beat(xsp_tb_pkg::KIND_SEED, 32'd1);
    repeat (2) offer_beat(xsp_tb_pkg::KIND_DRAW, 32'd0);
    offer_beat(xsp_tb_pkg::KIND_SEED, 32'hFFFF_FFFF);
    repeat (2) offer_beat(xsp_tb_pkg::KIND_DRAW, 32'd0);
    offer_beat(xsp_tb_pkg::KIND_SEED, 32'd0);
    offer_beat(xsp_tb_pkg::KIND_DRAW, 32'd0);

    write_base_seed({$urandom, $urandom});
    hold_go <= 1'b1;
    run_random(250);

    write_base_seed(64'h8000_0000_0000_0000);
    calm = 1'b1;
    run_random(250);
    calm = 1'b0;

    write_base_seed(64'hFFFF_FFFF_0000_0000);
    run_random(250);

    write_base_seed(64'h0);
    run_random(250);

    write_base_seed({$urandom, $urandom});
    run_random(230);

    drain_results();
    if (fail_count == 0 && results_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
